// File: rtl/vfve_pkg.sv
package vfve_pkg;

  // cluster edge in cells, cell coordinates wrap at this size
  localparam int CELL_EDGE = 16;

  localparam int NUM_FACES      = 6;
  localparam int VERTS_PER_FACE = 6;
  localparam int VERT_IDX_W     = $clog2(VERTS_PER_FACE);

  localparam int TEX_SPAN  = 256 / 8;
  localparam int TEX_INSET = 256 / 128;

  localparam logic [7:0] TEX_LO       = 8'(TEX_INSET);
  localparam logic [7:0] TEX_HI       = 8'(TEX_SPAN - TEX_INSET);
  localparam logic [7:0] SHADE_FULL   = 8'd255;
  localparam logic [7:0] SHADE_AO     = 8'd55;
  localparam logic [7:0] SHADE_SHADOW = 8'd90;

  // occluder bit positions
  localparam int OCC_TOP    = 0;
  localparam int OCC_BOTTOM = 1;
  localparam int OCC_LEFT   = 2;
  localparam int OCC_RIGHT  = 3;

  // corner entry bit positions: {x, z, y, u, v}
  localparam int CRN_X = 4;
  localparam int CRN_Z = 3;
  localparam int CRN_Y = 2;
  localparam int CRN_U = 1;
  localparam int CRN_V = 0;

  typedef logic [4:0] corner_t;

  localparam corner_t CORNER_TAB [NUM_FACES][VERTS_PER_FACE] = '{
    '{5'b01000, 5'b11010, 5'b11111, 5'b11111, 5'b01101, 5'b01000},  // +z
    '{5'b00010, 5'b00111, 5'b10101, 5'b10101, 5'b10000, 5'b00010},  // -z
    '{5'b10010, 5'b10111, 5'b11101, 5'b11101, 5'b11000, 5'b10010},  // +x
    '{5'b00000, 5'b01010, 5'b01111, 5'b01111, 5'b00101, 5'b00000},  // -x
    '{5'b00101, 5'b01100, 5'b11110, 5'b11110, 5'b10111, 5'b00101},  // +y
    '{5'b00001, 5'b10011, 5'b11010, 5'b11010, 5'b01000, 5'b00001}   // -y
  };

  // cell coordinate wrap table, 4-bit index
  typedef logic [15:0][3:0] cell_tab_t;

  function automatic cell_tab_t build_cell_tab();
    cell_tab_t tab;
    for (int i = 0; i < 16; i++) begin
      tab[i] = 4'(i % CELL_EDGE);
    end
    return tab;
  endfunction

  localparam cell_tab_t CELL_TAB = build_cell_tab();

  // one face with its world base already formed
  typedef struct packed {
    logic [15:0] base_x;
    logic [7:0]  base_y;
    logic [15:0] base_z;
    logic [2:0]  face;
    logic [3:0]  occ;
    logic [7:0]  tile_u;
    logic [7:0]  tile_v;
    logic        shadowed;
    logic        translucent;
  } face_rec_t;

  // one vertex slot of a face
  typedef struct packed {
    face_rec_t rec;
    corner_t   corner;
    logic      last;
  } vert_slot_t;

endpackage

// File: rtl/vfve_if.sv
interface vfve_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] origin_x;
  logic        [7:0]  origin_y;
  logic signed [15:0] origin_z;
  logic        [3:0]  cell_x;
  logic        [3:0]  cell_y;
  logic        [3:0]  cell_z;
  logic        [2:0]  face;
  logic        [3:0]  occluders;
  logic        [7:0]  tile_u;
  logic        [7:0]  tile_v;
  logic               shadowed;
  logic               translucent;

  modport source (
    output valid, origin_x, origin_y, origin_z, cell_x, cell_y, cell_z,
           face, occluders, tile_u, tile_v, shadowed, translucent,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, cell_x, cell_y, cell_z,
           face, occluders, tile_u, tile_v, shadowed, translucent,
    output ready
  );
endinterface

interface vfve_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vert_x;
  logic        [7:0]  vert_y;
  logic signed [15:0] vert_z;
  logic        [7:0]  tex_u;
  logic        [7:0]  tex_v;
  logic        [7:0]  shade;
  logic               pass_select;
  logic               last;

  modport source (
    output valid, vert_x, vert_y, vert_z, tex_u, tex_v, shade, pass_select, last,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, vert_z, tex_u, tex_v, shade, pass_select, last,
    output ready
  );
endinterface

// File: rtl/vfve_base.sv
module vfve_base (
  input  logic               clk,
  input  logic               rst_n,
  vfve_in_if.sink            in_item,
  output logic               rec_valid,
  input  logic               rec_ready,
  output vfve_pkg::face_rec_t rec
);
  import vfve_pkg::*;

  logic      valid_r, valid_nxt;
  face_rec_t rec_r, rec_nxt;
  logic      in_fire;
  logic [3:0] cx, cy, cz;

  assign in_item.ready = !valid_r || rec_ready;
  assign in_fire       = in_item.valid && in_item.ready;

  assign cx = CELL_TAB[in_item.cell_x];
  assign cy = CELL_TAB[in_item.cell_y];
  assign cz = CELL_TAB[in_item.cell_z];

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (in_fire) begin
      // face codes six and seven are taken and dropped
      valid_nxt           = (in_item.face < 3'(NUM_FACES));
      rec_nxt.base_x      = 16'(in_item.origin_x) + 16'(cx);
      rec_nxt.base_y      = in_item.origin_y + 8'(cy);
      rec_nxt.base_z      = 16'(in_item.origin_z) + 16'(cz);
      rec_nxt.face        = in_item.face;
      rec_nxt.occ         = in_item.occluders;
      rec_nxt.tile_u      = in_item.tile_u;
      rec_nxt.tile_v      = in_item.tile_v;
      rec_nxt.shadowed    = in_item.shadowed;
      rec_nxt.translucent = in_item.translucent;
    end else if (rec_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_valid = valid_r;
  assign rec       = rec_r;
endmodule

// File: rtl/vfve_expand.sv
module vfve_expand (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_valid,
  output logic                 rec_ready,
  input  vfve_pkg::face_rec_t  rec,
  output logic                 slot_valid,
  input  logic                 slot_ready,
  output vfve_pkg::vert_slot_t slot
);
  import vfve_pkg::*;

  localparam logic [VERT_IDX_W-1:0] LAST_VERT = VERT_IDX_W'(VERTS_PER_FACE - 1);

  logic                  valid_r, valid_nxt;
  face_rec_t             rec_r, rec_nxt;
  logic [VERT_IDX_W-1:0] k_r, k_nxt;
  logic                  is_last, slot_fire, rec_fire;

  assign is_last   = (k_r == LAST_VERT);
  assign slot_fire = valid_r && slot_ready;
  // next face loads as the last vertex of the current one leaves
  assign rec_ready = !valid_r || (slot_ready && is_last);
  assign rec_fire  = rec_valid && rec_ready;

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    k_nxt     = k_r;
    if (slot_fire) begin
      k_nxt = is_last ? '0 : k_r + 1'b1;
      if (is_last) begin
        valid_nxt = 1'b0;
      end
    end
    if (rec_fire) begin
      valid_nxt = 1'b1;
      rec_nxt   = rec;
      k_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign slot_valid  = valid_r;
  assign slot.rec    = rec_r;
  assign slot.corner = CORNER_TAB[rec_r.face][k_r];
  assign slot.last   = is_last;
endmodule

// File: rtl/vfve_vertex.sv
module vfve_vertex (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 slot_valid,
  output logic                 slot_ready,
  input  vfve_pkg::vert_slot_t slot,
  vfve_out_if.source           out_item
);
  import vfve_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] vx_r, vx_nxt;
  logic [7:0]  vy_r, vy_nxt;
  logic [15:0] vz_r, vz_nxt;
  logic [7:0]  tu_r, tu_nxt;
  logic [7:0]  tv_r, tv_nxt;
  logic [7:0]  shade_r, shade_nxt;
  logic        pass_r, pass_nxt;
  logic        last_r, last_nxt;
  logic        slot_fire, ao;
  logic        cu, cv;

  assign slot_ready = !valid_r || out_item.ready;
  assign slot_fire  = slot_valid && slot_ready;

  assign cu = slot.corner[CRN_U];
  assign cv = slot.corner[CRN_V];

  // corner touches a solid neighbor on its u or v side
  assign ao = (!cu && slot.rec.occ[OCC_LEFT])   || (cu && slot.rec.occ[OCC_RIGHT]) ||
              (!cv && slot.rec.occ[OCC_BOTTOM]) || (cv && slot.rec.occ[OCC_TOP]);

  always_comb begin
    valid_nxt = valid_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    vz_nxt    = vz_r;
    tu_nxt    = tu_r;
    tv_nxt    = tv_r;
    shade_nxt = shade_r;
    pass_nxt  = pass_r;
    last_nxt  = last_r;
    if (slot_fire) begin
      valid_nxt = 1'b1;
      vx_nxt    = slot.rec.base_x + 16'(slot.corner[CRN_X]);
      vy_nxt    = slot.rec.base_y + 8'(slot.corner[CRN_Y]);
      vz_nxt    = slot.rec.base_z + 16'(slot.corner[CRN_Z]);
      tu_nxt    = slot.rec.tile_u + (cu ? TEX_HI : TEX_LO);
      tv_nxt    = slot.rec.tile_v + (cv ? TEX_HI : TEX_LO);
      shade_nxt = SHADE_FULL - (ao ? SHADE_AO : 8'd0)
                             - (slot.rec.shadowed ? SHADE_SHADOW : 8'd0);
      pass_nxt  = slot.rec.translucent;
      last_nxt  = slot.last;
    end else if (out_item.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    vz_r    <= vz_nxt;
    tu_r    <= tu_nxt;
    tv_r    <= tv_nxt;
    shade_r <= shade_nxt;
    pass_r  <= pass_nxt;
    last_r  <= last_nxt;
  end

  assign out_item.valid       = valid_r;
  assign out_item.vert_x      = vx_r;
  assign out_item.vert_y      = vy_r;
  assign out_item.vert_z      = vz_r;
  assign out_item.tex_u       = tu_r;
  assign out_item.tex_v       = tv_r;
  assign out_item.shade       = shade_r;
  assign out_item.pass_select = pass_r;
  assign out_item.last        = last_r;
endmodule

// File: rtl/voxel_face_vertex_expander.sv
// voxel face vertex expander
// in_item carries one visible cube face per item: cluster origin, cell
// position, face code, neighbor occluder bits, texture tile base and the
// shadow and translucency flags. out_item returns the six vertices of the
// face's two triangles, one vertex item per cycle, last set on the sixth.
// both channels use valid/ready; an item moves when both are high.
// the face passes the base add stage, the vertex sequencer and the output
// register in that order before its first vertex is valid; the rest
// follow one per cycle while out_item.ready stays high.
// the vertex sequencer sets the face rate; it walks the six table slots
// of a face with a 3-bit counter. the next face is taken while the
// current one is still being expanded.
// face codes six and seven are accepted and produce no vertex.
// reset (rst_n low, synchronous) empties all stages; no face is held.
// when out_item.ready drops, the output register holds its vertex and the
// stages behind it fill and then stop taking items; nothing is lost.
module voxel_face_vertex_expander (
  input  logic       clk,
  input  logic       rst_n,
  vfve_in_if.sink    in_item,
  vfve_out_if.source out_item
);
  import vfve_pkg::*;

  // base stage to sequencer
  logic       rec_valid, rec_ready;
  face_rec_t  rec;

  // sequencer to vertex stage
  logic       slot_valid, slot_ready;
  vert_slot_t slot;

  // cell wrap and origin add
  vfve_base u_base (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // walks the corner table, one vertex slot per cycle while slot_ready is high
  vfve_expand u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot)
  );

  // position, texture and shade per vertex, output register
  vfve_vertex u_vertex (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot),
    .out_item   (out_item)
  );
endmodule

// File: tb/tb_top.sv
module tb_top;
  import vfve_pkg::CELL_EDGE;

  localparam int  CLK_HALF      = 5;
  localparam int  RANDOM_FACES  = 450;
  localparam int  DRAIN_CYCLES  = 16;
  localparam int  CYCLE_LIMIT   = 200000;
  localparam int  NUM_FACE_CODES = 6;
  localparam int  VERTS         = 6;

  // texture corner offsets inside a tile
  localparam logic [7:0] TEX_NEAR = 8'd2;
  localparam logic [7:0] TEX_FAR  = 8'd30;

  localparam logic [7:0] BRIGHT_FULL   = 8'd255;
  localparam logic [7:0] DIM_OCCLUDED  = 8'd55;
  localparam logic [7:0] DIM_SHADOW    = 8'd90;

  // occluder bits of a face
  localparam int NB_TOP    = 0;
  localparam int NB_BOTTOM = 1;
  localparam int NB_LEFT   = 2;
  localparam int NB_RIGHT  = 3;

  // per-vertex corner code, bits {x, z, y, u, v}
  localparam int CB_X = 4;
  localparam int CB_Z = 3;
  localparam int CB_Y = 2;
  localparam int CB_U = 1;
  localparam int CB_V = 0;

  // six vertices per face, two triangles, faces +z -z +x -x +y -y
  localparam logic [0:35][4:0] FACE_CORNERS = {
    5'b01000, 5'b11010, 5'b11111, 5'b11111, 5'b01101, 5'b01000,
    5'b00010, 5'b00111, 5'b10101, 5'b10101, 5'b10000, 5'b00010,
    5'b10010, 5'b10111, 5'b11101, 5'b11101, 5'b11000, 5'b10010,
    5'b00000, 5'b01010, 5'b01111, 5'b01111, 5'b00101, 5'b00000,
    5'b00101, 5'b01100, 5'b11110, 5'b11110, 5'b10111, 5'b00101,
    5'b00001, 5'b10011, 5'b11010, 5'b11010, 5'b01000, 5'b00001
  };

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic        [7:0]  origin_y;
    logic signed [15:0] origin_z;
    logic        [3:0]  cell_x;
    logic        [3:0]  cell_y;
    logic        [3:0]  cell_z;
    logic        [2:0]  face;
    logic        [3:0]  occluders;
    logic        [7:0]  tile_u;
    logic        [7:0]  tile_v;
    logic               shadowed;
    logic               translucent;
  } face_item_t;

  typedef struct packed {
    logic signed [15:0] vert_x;
    logic        [7:0]  vert_y;
    logic signed [15:0] vert_z;
    logic        [7:0]  tex_u;
    logic        [7:0]  tex_v;
    logic        [7:0]  shade;
    logic               pass_select;
    logic               last;
  } vertex_t;

  logic clk;
  logic rst_n;

  vfve_in_if  in_bus ();
  vfve_out_if out_bus ();

  voxel_face_vertex_expander dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  face_item_t pending_faces[$];
  vertex_t    expected_vertices[$];
  face_item_t face_on_bus;
  int         faces_taken;
  int         faces_total;
  int         mismatches;
  int         cycle_count;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // vertex prediction
  // ---------------------------------------------------------------------------

  // expand one accepted face into its six expected vertices
  task automatic expand_face(input face_item_t f);
    logic [4:0]  crn;
    logic [15:0] base_x;
    logic [7:0]  base_y;
    logic [15:0] base_z;
    logic        dark_corner;
    vertex_t     v;
    // face codes six and seven are dropped by the block
    if (f.face >= NUM_FACE_CODES) return;
    // cell coordinates wrap at the cluster edge before the add
    base_x = f.origin_x + 16'(f.cell_x % CELL_EDGE);
    base_y = f.origin_y + 8'(f.cell_y % CELL_EDGE);
    base_z = f.origin_z + 16'(f.cell_z % CELL_EDGE);
    for (int k = 0; k < VERTS; k++) begin
      crn = FACE_CORNERS[f.face * VERTS + k];
      // a corner touching a solid neighbor gets darker
      dark_corner = (!crn[CB_U] && f.occluders[NB_LEFT])   ||
                    ( crn[CB_U] && f.occluders[NB_RIGHT])  ||
                    (!crn[CB_V] && f.occluders[NB_BOTTOM]) ||
                    ( crn[CB_V] && f.occluders[NB_TOP]);
      v.vert_x = base_x + 16'(crn[CB_X]);
      v.vert_y = base_y + 8'(crn[CB_Y]);
      v.vert_z = base_z + 16'(crn[CB_Z]);
      v.tex_u  = (crn[CB_U] ? TEX_FAR : TEX_NEAR) + f.tile_u;
      v.tex_v  = (crn[CB_V] ? TEX_FAR : TEX_NEAR) + f.tile_v;
      v.shade  = BRIGHT_FULL;
      if (dark_corner) v.shade = v.shade - DIM_OCCLUDED;
      if (f.shadowed)  v.shade = v.shade - DIM_SHADOW;
      v.pass_select = f.translucent;
      v.last        = (k == VERTS - 1);
      expected_vertices.push_back(v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // idle rates by thirds of the run: sender light, then receiver light, then none
  function automatic int sender_idle_pct();
    int third;
    third = (faces_total == 0) ? 0 : (faces_taken * 3) / faces_total;
    case (third)
      0:       return 12;
      1:       return 67;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    int third;
    third = (faces_total == 0) ? 0 : (faces_taken * 3) / faces_total;
    case (third)
      0:       return 67;
      1:       return 12;
      default: return 0;
    endcase
  endfunction

  // 16-bit origin, now and then pinned to a wrap edge
  function automatic logic [15:0] pick_origin16();
    logic [15:0] edges [4];
    edges = '{16'h8000, 16'h7fff, 16'hffff, 16'h0000};
    if (roll(15)) return edges[$urandom_range(3, 0)];
    return 16'($urandom);
  endfunction

  function automatic face_item_t random_face();
    face_item_t f;
    f.origin_x    = pick_origin16();
    f.origin_y    = roll(15) ? 8'd255 : 8'($urandom);
    f.origin_z    = pick_origin16();
    f.cell_x      = 4'($urandom);
    f.cell_y      = 4'($urandom);
    f.cell_z      = 4'($urandom);
    // mostly real faces, a few dropped codes as noise
    f.face        = roll(5) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
    f.occluders   = 4'($urandom);
    f.tile_u      = roll(15) ? 8'hff : 8'($urandom);
    f.tile_v      = roll(15) ? 8'hff : 8'($urandom);
    f.shadowed    = 1'($urandom);
    f.translucent = 1'($urandom);
    return f;
  endfunction

  task automatic queue_face(input face_item_t f);
    pending_faces.push_back(f);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one face item on the bus, held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expand_face(face_on_bus);
        faces_taken++;
      end
      // the bus is free when nothing is offered or the offer was just taken
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_faces.size() != 0 && !roll(sender_idle_pct())) begin
          face_on_bus = pending_faces.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.origin_x    <= face_on_bus.origin_x;
          in_bus.origin_y    <= face_on_bus.origin_y;
          in_bus.origin_z    <= face_on_bus.origin_z;
          in_bus.cell_x      <= face_on_bus.cell_x;
          in_bus.cell_y      <= face_on_bus.cell_y;
          in_bus.cell_z      <= face_on_bus.cell_z;
          in_bus.face        <= face_on_bus.face;
          in_bus.occluders   <= face_on_bus.occluders;
          in_bus.tile_u      <= face_on_bus.tile_u;
          in_bus.tile_v      <= face_on_bus.tile_v;
          in_bus.shadowed    <= face_on_bus.shadowed;
          in_bus.translucent <= face_on_bus.translucent;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: compare each taken vertex with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_vertex();
    vertex_t want;
    if (expected_vertices.size() == 0) begin
      $error("vertex with no face pending: x=%0d y=%0d z=%0d",
             out_bus.vert_x, out_bus.vert_y, out_bus.vert_z);
      mismatches++;
      return;
    end
    want = expected_vertices.pop_front();
    if (out_bus.vert_x !== want.vert_x) begin
      $error("vert_x expected %0d got %0d", want.vert_x, out_bus.vert_x);
      mismatches++;
    end
    if (out_bus.vert_y !== want.vert_y) begin
      $error("vert_y expected %0d got %0d", want.vert_y, out_bus.vert_y);
      mismatches++;
    end
    if (out_bus.vert_z !== want.vert_z) begin
      $error("vert_z expected %0d got %0d", want.vert_z, out_bus.vert_z);
      mismatches++;
    end
    if (out_bus.tex_u !== want.tex_u) begin
      $error("tex_u expected %0d got %0d", want.tex_u, out_bus.tex_u);
      mismatches++;
    end
    if (out_bus.tex_v !== want.tex_v) begin
      $error("tex_v expected %0d got %0d", want.tex_v, out_bus.tex_v);
      mismatches++;
    end
    if (out_bus.shade !== want.shade) begin
      $error("shade expected %0d got %0d", want.shade, out_bus.shade);
      mismatches++;
    end
    if (out_bus.pass_select !== want.pass_select) begin
      $error("pass_select expected %0d got %0d", want.pass_select, out_bus.pass_select);
      mismatches++;
    end
    if (out_bus.last !== want.last) begin
      $error("last expected %0d got %0d", want.last, out_bus.last);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) check_vertex();
      out_bus.ready <= !roll(receiver_idle_pct());
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int real_faces;
    face_item_t f;

    faces_taken = 0;
    faces_total = 0;
    mismatches  = 0;
    cycle_count = 0;
    real_faces  = 0;

    // known levels on every input before the first edge
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.origin_x    = '0;
    in_bus.origin_y    = '0;
    in_bus.origin_z    = '0;
    in_bus.cell_x      = '0;
    in_bus.cell_y      = '0;
    in_bus.cell_z      = '0;
    in_bus.face        = '0;
    in_bus.occluders   = '0;
    in_bus.tile_u      = '0;
    in_bus.tile_v      = '0;
    in_bus.shadowed    = 1'b0;
    in_bus.translucent = 1'b0;
    out_bus.ready      = 1'b0;

    // directed: zero face, all extremes with every wrap at once
    queue_face('{16'sh0000, 8'd0, 16'sh0000, 4'd0, 4'd0, 4'd0, 3'd0, 4'h0,
                 8'd0, 8'd0, 1'b0, 1'b0});
    queue_face('{16'sh7fff, 8'd255, 16'sh7fff, 4'd15, 4'd15, 4'd15, 3'd0, 4'hf,
                 8'd255, 8'd255, 1'b1, 1'b1});
    queue_face('{16'sh8000, 8'd0, 16'sh8000, 4'd0, 4'd0, 4'd0, 3'd1, 4'h1,
                 8'd0, 8'd255, 1'b0, 1'b0});
    queue_face('{16'shffff, 8'd240, 16'shffff, 4'd15, 4'd15, 4'd15, 3'd2, 4'h2,
                 8'd255, 8'd0, 1'b1, 1'b0});
    queue_face('{16'sh0064, 8'd64, 16'shff9c, 4'd3, 4'd7, 4'd9, 3'd3, 4'h4,
                 8'd17, 8'd200, 1'b0, 1'b1});
    queue_face('{16'sh1234, 8'h80, 16'shedcb, 4'd8, 4'd1, 4'd14, 3'd4, 4'h8,
                 8'd226, 8'd225, 1'b1, 1'b1});
    queue_face('{16'shff38, 8'd254, 16'sh012c, 4'd15, 4'd0, 4'd15, 3'd5, 4'h0,
                 8'd224, 8'd226, 1'b0, 1'b0});
    // dropped face codes, six and seven
    queue_face('{16'sh5555, 8'haa, 16'shaaaa, 4'd5, 4'd10, 4'd5, 3'd6, 4'h5,
                 8'h55, 8'haa, 1'b1, 1'b0});
    queue_face('{16'shaaaa, 8'h55, 16'sh5555, 4'd10, 4'd5, 4'd10, 3'd7, 4'ha,
                 8'haa, 8'h55, 1'b0, 1'b1});
    // every face fully occluded and shadowed, darkest shade
    for (int fc = 0; fc < NUM_FACE_CODES; fc++) begin
      f = random_face();
      f.face      = 3'(fc);
      f.occluders = 4'hf;
      f.shadowed  = 1'b1;
      queue_face(f);
    end
    // one occluder at a time, lit
    for (int b = 0; b < 4; b++) begin
      f = random_face();
      f.face      = 3'($urandom_range(5, 0));
      f.occluders = 4'(1 << b);
      f.shadowed  = 1'b0;
      queue_face(f);
    end

    // random faces with a few dropped codes mixed in
    while (real_faces < RANDOM_FACES) begin
      f = random_face();
      queue_face(f);
      if (f.face < NUM_FACE_CODES) real_faces++;
    end
    faces_total = pending_faces.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // all faces offered and taken, every vertex back
    while (pending_faces.size() != 0 || in_bus.valid || expected_vertices.size() != 0)
      @(posedge clk);
    // watch for stray vertices behind the last face
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
